/* rtl/core/numeric_format_converter_unit_assert.svh */
// Assertion macros used by the converter unit.
`ifndef NUMERIC_FORMAT_CONVERTER_UNIT_ASSERT_SVH
`define NUMERIC_FORMAT_CONVERTER_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define NFC_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after, outside reset.
`define NFC_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error(msg);

`endif

/* rtl/core/nfc_pkg.sv */
`timescale 1ns / 1ps
package nfc_pkg;

  typedef enum logic [2:0] {
    CONV_F32_I32   = 3'd0,
    CONV_F32_BF16  = 3'd1,
    CONV_BF16_F32  = 3'd2,
    CONV_I32_F32   = 3'd3,
    CONV_I32_I8    = 3'd4,
    CONV_I8_F32    = 3'd5,
    CONV_I8_I32    = 3'd6,
    CONV_F32_BF16T = 3'd7
  } conv_t;

  localparam logic [31:0] INT32_INVALID = 32'h8000_0000;
  localparam logic [31:0] BF16_BIAS     = 32'h0000_7FFF;
  localparam logic [7:0]  INT8_MAX      = 8'h7F;
  localparam logic [7:0]  INT8_MIN      = 8'h80;
  localparam int unsigned BF16_SHIFT    = 16;

  typedef struct packed {
    logic [31:0] source_bits;
    logic        last_in;
  } nfc_in_t;

  typedef struct packed {
    logic [31:0] result_bits;
    logic        clamped;
    logic        last_out;
  } nfc_out_t;

endpackage

/* rtl/core/nfc_f2i.sv */
`timescale 1ns / 1ps
module nfc_f2i
  import nfc_pkg::*;
(
  input  logic [31:0] src,
  output logic [31:0] res,
  output logic        clamp
);

  logic [7:0]  e;
  logic [23:0] mant;
  logic [31:0] mag;
  logic [55:0] wide;
  logic [5:0]  sh;
  logic [63:0] rounded;
  logic        lsb, rnd, sticky, neg;

  always_comb begin
    e      = src[30:23];
    neg    = src[31];
    mant   = (e != 8'd0) ? {1'b1, src[22:0]} : {1'b0, src[22:0]};
    wide   = '0;
    sh     = '0;
    mag    = '0;
    lsb    = 1'b0;
    rnd    = 1'b0;
    sticky = 1'b0;
    rounded = '0;
    if (e >= 8'd150) begin
      // Left shift by e-150; e>=190 also reaches here and is clamped below, so valid results use at most 39 shifts.
      rounded = {40'd0, mant} << (e - 8'd150);
    end else begin
      sh = ((8'd150 - e) > 8'd26) ? 6'd26 : 6'((8'd150 - e));
      // mant placed with 32 fraction bits below
      wide    = {mant, 32'd0} >> sh;
      mag     = {8'd0, wide[55:32]};
      lsb     = wide[32];
      rnd     = wide[31];
      sticky  = |wide[30:0];
      rounded = {32'd0, mag} + 64'(rnd & (sticky | lsb));
    end
    if (e == 8'hFF || e >= 8'd190 ||
        (!neg && rounded > 64'h0000_0000_7FFF_FFFF) ||
        (neg && rounded > 64'h0000_0000_8000_0000)) begin
      res   = INT32_INVALID;
      clamp = 1'b1;
    end else begin
      res   = neg ? (32'd0 - rounded[31:0]) : rounded[31:0];
      clamp = 1'b0;
    end
  end

endmodule

/* rtl/core/nfc_i2f.sv */
`timescale 1ns / 1ps
module nfc_i2f
  import nfc_pkg::*;
(
  input  logic [31:0] src,
  output logic [31:0] res
);

  logic [31:0] mag, norm;
  logic [4:0]  p;
  logic [24:0] q;
  logic [7:0]  expo;
  logic        rnd, sticky;

  always_comb begin
    mag = src[31] ? (32'd0 - src) : src;
    p   = '0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) p = 5'(i);
    end
    norm   = mag << (5'd31 - p);
    rnd    = norm[7];
    sticky = |norm[6:0];
    q      = {1'b0, norm[31:8]} + 25'(rnd & (sticky | norm[8]));
    expo   = 8'(p) + 8'd127;
    if (q[24]) begin
      expo = expo + 8'd1;
      q    = q >> 1;
    end
    if (mag == 32'd0) res = '0;
    else res = {src[31], expo, q[22:0]};
  end

endmodule

/* rtl/core/nfc_datapath.sv */
`timescale 1ns / 1ps
module nfc_datapath
  import nfc_pkg::*;
(
  input  conv_t       conv,
  input  nfc_in_t     din,
  output nfc_out_t    dout
);

  logic [31:0] src, s8, f2i_res, i2f_src, i2f_res, bsum;
  logic        f2i_clamp;

  assign src = din.source_bits;
  assign s8  = {{24{src[7]}}, src[7:0]};
  assign i2f_src = (conv == CONV_I8_F32) ? s8 : src;
  assign bsum = src + BF16_BIAS + {31'd0, src[16]};

  nfc_f2i u_f2i (.src(src), .res(f2i_res), .clamp(f2i_clamp));
  nfc_i2f u_i2f (.src(i2f_src), .res(i2f_res));

  always_comb begin
    dout.last_out = din.last_in;
    dout.clamped  = 1'b0;
    unique case (conv) inside
      CONV_F32_I32: begin
        dout.result_bits = f2i_res;
        dout.clamped     = f2i_clamp;
      end
      CONV_F32_BF16:  dout.result_bits = bsum >> BF16_SHIFT;
      CONV_BF16_F32:  dout.result_bits = {src[15:0], 16'd0};
      CONV_I32_F32, CONV_I8_F32: dout.result_bits = i2f_res;
      CONV_I32_I8: begin
        if (!src[31] && src > 32'd127) begin
          dout.result_bits = {24'd0, INT8_MAX};
          dout.clamped     = 1'b1;
        end else if (src[31] && src < 32'hFFFF_FF80) begin
          dout.result_bits = {24'd0, INT8_MIN};
          dout.clamped     = 1'b1;
        end else begin
          dout.result_bits = {24'd0, src[7:0]};
        end
      end
      CONV_I8_I32:    dout.result_bits = s8;
      default:        dout.result_bits = src >> BF16_SHIFT;
    endcase
  end

endmodule

/* rtl/core/numeric_format_converter_unit.sv */
`timescale 1ns / 1ps
// Elementwise format converter for tensor streams.
// Input channel: in_valid / in_ready carry one element (source_bits and the
// last_in mark) per transfer. Output channel: out_valid / out_ready carry the
// converted element, its clamped flag and last_out.
// The conversion is chosen by cfg_we / cfg_data; write it only while the
// block is idle, as it applies to elements still in flight.
// An accepted element is captured in the input register, converted by
// short logic while it sits there and loaded into the result register
// when that register is empty or being taken; the result is offered
// from the result register.
// Throughput is one element per cycle unless the receiver stalls: each
// register stage advances when the stage after it is empty or moving, so
// the block takes a new element while an earlier result waits at the output.
// When the receiver stalls, the result register holds and the input
// register fills; then in_ready falls until the output is taken.
// A synchronous reset empties both stages and sets the conversion to
// fp32 to int32.
`include "numeric_format_converter_unit_assert.svh"
module numeric_format_converter_unit
  import nfc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  nfc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output nfc_out_t out_data,
  input  logic     cfg_we,
  input  logic [2:0] cfg_data
);

  conv_t    conv;
  nfc_in_t  stage;
  logic     stage_valid;
  nfc_out_t conv_out;
  logic     out_move, stage_move;

  // The result register moves when empty or being taken.
  assign out_move   = !out_valid || out_ready;
  assign stage_move = !stage_valid || out_move;
  assign in_ready   = stage_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      conv <= CONV_F32_I32;
    end else if (cfg_we) begin
      conv <= conv_t'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (stage_move) stage_valid <= in_valid;
      if (out_move)   out_valid   <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_move && in_valid) stage <= in_data;
    if (out_move && stage_valid) out_data <= conv_out;
  end

  nfc_datapath u_dp (.conv(conv), .din(stage), .dout(conv_out));

  `NFC_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid,
                   "result dropped while stalled")
  `NFC_ASSERT_IMP(a_ready, clk, rst, stage_valid && out_valid && !out_ready,
                  !in_ready, "accepting with both stages full")
  `NFC_ASSERT_NEXT(a_fill, clk, rst, stage_valid && out_move, out_valid,
                   "stage item not moved to output")

endmodule
